// ===== design/bdq_pkg.sv =====
// shared types, widths and operation codes for the bounded deque
// no dependencies
package bdq_pkg;

    localparam int VALUE_W       = 32;
    localparam int KIND_W        = 2;
    localparam int CAP_W         = 11;
    localparam int DEPTH_DEFAULT = 1024;

    typedef logic [KIND_W-1:0]         kind_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CAP_W-1:0]          cap_t;

    localparam kind_t KIND_PUSH_FRONT = 2'd0;
    localparam kind_t KIND_PUSH_REAR  = 2'd1;
    localparam kind_t KIND_POP_FRONT  = 2'd2;
    localparam kind_t KIND_POP_REAR   = 2'd3;

    localparam cap_t   CAP_RESET   = 11'd1024;
    localparam value_t EMPTY_VALUE = -32'sd1;

endpackage

// ===== design/bdq_if.sv =====
// operation and result channel interfaces for the bounded deque
// depends on bdq_pkg
interface bdq_in_if;
    logic            valid;
    logic            ready;
    bdq_pkg::kind_t  kind;
    bdq_pkg::value_t value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bdq_out_if;
    logic            valid;
    logic            ready;
    logic            ok;
    bdq_pkg::value_t front_value;
    bdq_pkg::value_t rear_value;
    logic            is_empty;
    logic            is_full;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

// ===== design/bounded_double_ended_queue.sv =====
// bounded double-ended queue of signed 32-bit words held in a ring buffer
// depends on bdq_pkg, bdq_if and bdq_mem
//
// usage:
//   req carries one operation word (kind, value); rsp returns one result word
//   per operation (ok, front_value, rear_value, is_empty, is_full) describing
//   the queue after the operation. both use valid/ready.
//   cfg_wr_en/cfg_wr_data write the capacity; write only while idle.
// result path:
//   inserts, failed operations and removals that empty the queue: result
//   registered in the cycle after acceptance; one operation per cycle while
//   rsp.ready is high. successful removals that leave entries: the new end
//   entry is read from the entry memory (registered read, ST_READ state), then
//   the result is registered; no new operation is taken until that read is done.
// reset: queue empty, pointers zero, capacity 1024; no memory clearing.
// stall: the result register holds its word while rsp.ready is low and
//   req.ready stays low until that word is taken or leaves the same cycle.
module bounded_double_ended_queue #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  bdq_pkg::cap_t     cfg_wr_data,
    bdq_in_if.sink            req,
    bdq_out_if.source         rsp
);
    import bdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : AW'(i + 1'b1);
    endfunction

    function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : AW'(i - 1'b1);
    endfunction

    logic          state_reg, state_next;
    logic          side_front_reg, side_front_next;
    cap_t          cap_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] front_idx_reg, front_idx_next;
    logic [AW-1:0] rear_idx_reg, rear_idx_next;
    value_t        front_val_reg, front_val_next;
    value_t        rear_val_reg, rear_val_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_ok_reg, out_ok_next;
    value_t        out_front_reg, out_front_next;
    value_t        out_rear_reg, out_rear_next;
    logic          out_empty_reg, out_empty_next;
    logic          out_full_reg, out_full_next;

    logic [LW-1:0] limit;
    logic          full_now;
    logic          accept;
    logic          ok;
    logic          need_read;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    value_t        rd_data;

    bdq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign limit     = (LW'(cap_reg) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_reg);
    assign full_now  = LW'(count_reg) >= limit;
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next      = state_reg;
        side_front_next = side_front_reg;
        count_next      = count_reg;
        front_idx_next  = front_idx_reg;
        rear_idx_next   = rear_idx_reg;
        front_val_next  = front_val_reg;
        rear_val_next   = rear_val_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_ok_next     = out_ok_reg;
        out_front_next  = out_front_reg;
        out_rear_next   = out_rear_reg;
        out_empty_next  = out_empty_reg;
        out_full_next   = out_full_reg;
        ok              = 1'b0;
        need_read       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = front_idx_reg;
        rd_en           = 1'b0;
        rd_addr         = front_idx_reg;

        if (accept)
        begin
            case (req.kind)
                KIND_PUSH_FRONT:
                begin
                    if (!full_now)
                    begin
                        ok             = 1'b1;
                        front_idx_next = prev_slot(front_idx_reg);
                        wr_en          = 1'b1;
                        wr_addr        = front_idx_next;
                        count_next     = count_reg + 1'b1;
                        front_val_next = req.value;
                        if (count_reg == '0)
                        begin
                            rear_val_next = req.value;
                        end
                    end
                end
                KIND_PUSH_REAR:
                begin
                    if (!full_now)
                    begin
                        ok            = 1'b1;
                        wr_en         = 1'b1;
                        wr_addr       = rear_idx_reg;
                        rear_idx_next = next_slot(rear_idx_reg);
                        count_next    = count_reg + 1'b1;
                        rear_val_next = req.value;
                        if (count_reg == '0)
                        begin
                            front_val_next = req.value;
                        end
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (count_reg != '0)
                    begin
                        ok              = 1'b1;
                        front_idx_next  = next_slot(front_idx_reg);
                        count_next      = count_reg - 1'b1;
                        need_read       = (count_next != '0);
                        rd_addr         = front_idx_next;
                        side_front_next = 1'b1;
                    end
                end
                default:
                begin
                    if (count_reg != '0)
                    begin
                        ok              = 1'b1;
                        rear_idx_next   = prev_slot(rear_idx_reg);
                        count_next      = count_reg - 1'b1;
                        need_read       = (count_next != '0);
                        rd_addr         = prev_slot(rear_idx_next);
                        side_front_next = 1'b0;
                    end
                end
            endcase

            rd_en = need_read;
            if (need_read)
            begin
                state_next = ST_READ;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_ok_next    = ok;
                out_empty_next = (count_next == '0);
                out_full_next  = LW'(count_next) >= limit;
                out_front_next = (count_next == '0) ? EMPTY_VALUE : front_val_next;
                out_rear_next  = (count_next == '0) ? EMPTY_VALUE : rear_val_next;
            end
        end

        // new end entry arrives from memory
        if (state_reg == ST_READ)
        begin
            state_next     = ST_IDLE;
            out_valid_next = 1'b1;
            out_ok_next    = 1'b1;
            out_empty_next = 1'b0;
            out_full_next  = full_now;
            if (side_front_reg)
            begin
                front_val_next = rd_data;
                out_front_next = rd_data;
                out_rear_next  = rear_val_reg;
            end
            else
            begin
                rear_val_next  = rd_data;
                out_front_next = front_val_reg;
                out_rear_next  = rd_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            side_front_reg <= 1'b0;
            cap_reg        <= CAP_RESET;
            count_reg      <= '0;
            front_idx_reg  <= '0;
            rear_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            side_front_reg <= side_front_next;
            count_reg      <= count_next;
            front_idx_reg  <= front_idx_next;
            rear_idx_reg   <= rear_idx_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        front_val_reg <= front_val_next;
        rear_val_reg  <= rear_val_next;
        out_ok_reg    <= out_ok_next;
        out_front_reg <= out_front_next;
        out_rear_reg  <= out_rear_next;
        out_empty_reg <= out_empty_next;
        out_full_reg  <= out_full_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.front_value = out_front_reg;
    assign rsp.rear_value  = out_rear_reg;
    assign rsp.is_empty    = out_empty_reg;
    assign rsp.is_full     = out_full_reg;

endmodule

// ===== design/bdq_mem.sv =====
// entry storage: one write port, one read port, registered read data
// depends on bdq_pkg
module bdq_mem #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  bdq_pkg::value_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output bdq_pkg::value_t rd_data
);
    import bdq_pkg::*;

    value_t entry_mem [DEPTH];
    value_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== dv/bounded_double_ended_queue_test.sv =====
`timescale 1ns / 1ps
// testbench for bounded_double_ended_queue: a directed table, then random operation words
// with bursty input and stalling output, checked against a ring buffer predictor
// depends on bdq_pkg, bdq_if and the rtl of bounded_double_ended_queue
module bounded_double_ended_queue_test;
    import bdq_pkg::*;

    localparam int QDEPTH      = DEPTH_DEFAULT;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;
    localparam int PHASE_LEN   = 32;

    localparam value_t TOP  = 32'sh7FFF_FFFF;
    localparam value_t BOT  = 32'sh8000_0000;
    localparam value_t ALT5 = 32'sh5555_5555;
    localparam value_t ALTA = 32'shAAAA_AAAA;

    typedef struct packed {
        logic   ok;
        value_t front_value;
        value_t rear_value;
        logic   is_empty;
        logic   is_full;
    } deque_result_t;

    typedef enum logic {ROW_OP, ROW_CAP} row_act_t;

    typedef struct packed {
        row_act_t      act;
        cap_t          cap;
        kind_t         kind;
        value_t        value;
        logic          typed;
        deque_result_t want;
    } script_row_t;

    typedef enum logic [1:0] {RX_FLOW, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} stall_mode_t;

    localparam deque_result_t NONE_EMPTY = '{1'b1, EMPTY_VALUE, EMPTY_VALUE, 1'b1, 1'b0};
    localparam deque_result_t MISS_EMPTY = '{1'b0, EMPTY_VALUE, EMPTY_VALUE, 1'b1, 1'b0};
    localparam deque_result_t MISS_ZERO  = '{1'b0, EMPTY_VALUE, EMPTY_VALUE, 1'b1, 1'b1};
    localparam deque_result_t NOCHK      = '0;

    localparam int SCRIPT_LEN = 28;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{ROW_OP,  11'd0,    KIND_POP_FRONT,  32'sd5,       1'b1, MISS_EMPTY},
        '{ROW_OP,  11'd0,    KIND_POP_REAR,   EMPTY_VALUE,  1'b1, MISS_EMPTY},
        '{ROW_OP,  11'd0,    KIND_PUSH_FRONT, TOP,          1'b1,
          '{1'b1, TOP, TOP, 1'b0, 1'b0}},
        '{ROW_OP,  11'd0,    KIND_PUSH_REAR,  BOT,          1'b1,
          '{1'b1, TOP, BOT, 1'b0, 1'b0}},
        '{ROW_OP,  11'd0,    KIND_PUSH_FRONT, 32'sd0,       1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_PUSH_REAR,  EMPTY_VALUE,  1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_POP_REAR,   32'sd9,       1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_POP_FRONT,  32'sd0,       1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_POP_FRONT,  32'sd0,       1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_POP_REAR,   32'sd0,       1'b1, NONE_EMPTY},
        '{ROW_CAP, 11'd0,    KIND_PUSH_FRONT, 32'sd0,       1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_PUSH_REAR,  32'sd1,       1'b1, MISS_ZERO},
        '{ROW_OP,  11'd0,    KIND_PUSH_FRONT, 32'sd2,       1'b1, MISS_ZERO},
        '{ROW_OP,  11'd0,    KIND_POP_FRONT,  32'sd0,       1'b1, MISS_ZERO},
        '{ROW_CAP, 11'd1,    KIND_PUSH_FRONT, 32'sd0,       1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_PUSH_REAR,  ALT5,         1'b1,
          '{1'b1, ALT5, ALT5, 1'b0, 1'b1}},
        '{ROW_OP,  11'd0,    KIND_PUSH_FRONT, ALTA,         1'b1,
          '{1'b0, ALT5, ALT5, 1'b0, 1'b1}},
        '{ROW_CAP, 11'd3,    KIND_PUSH_FRONT, 32'sd0,       1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_PUSH_FRONT, 32'sh1234_5678, 1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_PUSH_REAR,  32'sh0F0F_0F0F, 1'b0, NOCHK},
        '{ROW_CAP, 11'd1,    KIND_PUSH_FRONT, 32'sd0,       1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_PUSH_REAR,  32'sd7,       1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_POP_FRONT,  ALTA,         1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_POP_REAR,   TOP,          1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_POP_REAR,   BOT,          1'b1, NONE_EMPTY},
        '{ROW_CAP, 11'd2047, KIND_PUSH_FRONT, 32'sd0,       1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_PUSH_FRONT, 32'sd3,       1'b0, NOCHK},
        '{ROW_OP,  11'd0,    KIND_POP_REAR,   32'sd0,       1'b0, NOCHK}
    };

    localparam int PHASE_COUNT = 7;
    localparam cap_t PHASE_CAP [PHASE_COUNT] = '{11'd2, 11'd0, 11'd5, 11'd1, 11'd16, 11'd3,
                                                 CAP_RESET};

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    cap_t cfg_wr_data;

    bdq_in_if  req_ch();
    bdq_out_if rsp_ch();

    value_t          ring [QDEPTH];
    int unsigned     head_slot;
    int unsigned     tail_slot;
    int unsigned     live_count;
    cap_t            capacity_reg;
    deque_result_t   expected_results [$];
    int unsigned     burst_left;
    int unsigned     mismatch_count;
    int unsigned     quiet_cycles;
    bit              hold_off_request;

    bounded_double_ended_queue #(.DEPTH(QDEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic deque_result_t apply_op(input kind_t k, input value_t v);
        deque_result_t r;
        int unsigned   lim;
        lim = (capacity_reg > QDEPTH) ? QDEPTH : capacity_reg;
        r.ok = 1'b0;
        case (k)
            KIND_PUSH_FRONT:
                if (live_count < lim)
                begin
                    head_slot = (head_slot == 0) ? QDEPTH - 1 : head_slot - 1;
                    ring[head_slot] = v;
                    live_count++;
                    r.ok = 1'b1;
                end
            KIND_PUSH_REAR:
                if (live_count < lim)
                begin
                    ring[tail_slot] = v;
                    tail_slot = (tail_slot == QDEPTH - 1) ? 0 : tail_slot + 1;
                    live_count++;
                    r.ok = 1'b1;
                end
            KIND_POP_FRONT:
                if (live_count != 0)
                begin
                    head_slot = (head_slot == QDEPTH - 1) ? 0 : head_slot + 1;
                    live_count--;
                    r.ok = 1'b1;
                end
            default:
                if (live_count != 0)
                begin
                    tail_slot = (tail_slot == 0) ? QDEPTH - 1 : tail_slot - 1;
                    live_count--;
                    r.ok = 1'b1;
                end
        endcase
        if (live_count == 0)
        begin
            r.front_value = EMPTY_VALUE;
            r.rear_value  = EMPTY_VALUE;
            r.is_empty    = 1'b1;
        end
        else
        begin
            r.front_value = ring[head_slot];
            r.rear_value  = ring[(tail_slot == 0) ? QDEPTH - 1 : tail_slot - 1];
            r.is_empty    = 1'b0;
        end
        r.is_full = (live_count >= lim);
        return r;
    endfunction

    function automatic value_t pick_value();
        case ($urandom_range(0, 15))
            0:       return TOP;
            1:       return BOT;
            2:       return EMPTY_VALUE;
            3:       return '0;
            default: return value_t'($urandom);
        endcase
    endfunction

    // push_weight out of 64
    function automatic kind_t choose_kind(input int unsigned push_weight);
        if ($urandom_range(0, 63) < push_weight)
            return ($urandom_range(0, 1) != 0) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
        return ($urandom_range(0, 1) != 0) ? KIND_POP_REAR : KIND_POP_FRONT;
    endfunction

    task automatic issue(input kind_t k, input value_t v, input logic typed,
                         input deque_result_t want);
        int unsigned   gap;
        deque_result_t model_res;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.kind  <= k;
        req_ch.value <= v;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
        model_res = apply_op(k, v);
        expected_results.push_back(typed ? want : model_res);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic set_capacity(input cap_t c);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_reg = c;
    endtask

    initial
    begin
        bit          seen_full;
        int unsigned tail_ops;
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_PUSH_FRONT;
        req_ch.value <= '0;
        head_slot        = 0;
        tail_slot        = 0;
        live_count       = 0;
        capacity_reg     = CAP_RESET;
        burst_left       = 0;
        mismatch_count   = 0;
        hold_off_request = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (SCRIPT[i].act == ROW_CAP)
                set_capacity(SCRIPT[i].cap);
            else
                issue(SCRIPT[i].kind, SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].want);
        end

        // fill then drain at each capacity in PHASE_CAP
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_capacity(PHASE_CAP[p]);
            for (int n = 0; n < PHASE_LEN; n++)
                issue(choose_kind((n < PHASE_LEN / 2) ? 48 : 16), pick_value(), 1'b0, NOCHK);
        end

        // capacity above the ring size, filled until the ring itself is full
        set_capacity(11'd2047);
        hold_off_request = 1'b1;
        seen_full = 1'b0;
        tail_ops  = 40;
        while (tail_ops != 0)
        begin
            if (seen_full)
            begin
                issue(choose_kind(32), pick_value(), 1'b0, NOCHK);
                tail_ops--;
            end
            else
                issue(choose_kind(63), pick_value(), 1'b0, NOCHK);
            if (live_count >= QDEPTH)
                seen_full = 1'b1;
        end

        // capacity dropped far below the live count
        set_capacity(11'd1);
        for (int n = 0; n < 40; n++)
            issue(choose_kind(24), pick_value(), 1'b0, NOCHK);

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("bounded_double_ended_queue_test passed");
        else
            $display("bounded_double_ended_queue_test failed");
        $finish;
    end

    initial
    begin
        stall_mode_t mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode      = RX_FLOW;
        mode_left = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp_ch.ready <= 1'b0;
            else if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    RX_FLOW:   rsp_ch.ready <= 1'b1;
                    RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_ch.ready <= (mode_left % 5 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        deque_result_t got;
        deque_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got = '{rsp_ch.ok, rsp_ch.front_value, rsp_ch.rear_value,
                    rsp_ch.is_empty, rsp_ch.is_full};
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: ok=%0b front=%0d rear=%0d empty=%0b full=%0b",
                             got.ok, got.front_value, got.rear_value, got.is_empty, got.is_full);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.ok !== want.ok || got.front_value !== want.front_value ||
                    got.rear_value !== want.rear_value || got.is_empty !== want.is_empty ||
                    got.is_full !== want.is_full)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch: expected ok=%0b front=%0d rear=%0d ",
                                  "empty=%0b full=%0b, got ok=%0b front=%0d rear=%0d ",
                                  "empty=%0b full=%0b"},
                                 want.ok, want.front_value, want.rear_value, want.is_empty,
                                 want.is_full, got.ok, got.front_value, got.rear_value,
                                 got.is_empty, got.is_full);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                 (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("bounded_double_ended_queue_test failed");
                $finish;
            end
        end
    end

endmodule

// ===== bounded_double_ended_queue.f =====
design/bdq_pkg.sv
design/bdq_if.sv
design/bdq_mem.sv
design/bounded_double_ended_queue.sv
dv/bounded_double_ended_queue_test.sv
